>>> rtl/core/hcre_pkg.sv
// shared constants, pipeline timeline and types for the hit coordinate converter
// no dependencies; imported by every module of the block except hcre_delay
`timescale 1ns / 1ps

package hcre_pkg;

   // root unit: one result bit per stage over a 64-bit radicand
   localparam int SQRT_STAGES = 32;

   // log2 unit: leading-one search then one squaring per fraction bit
   localparam int LOG_FRAC        = 20;
   localparam int LOG_EXP_W       = 6;
   localparam int LOG_W           = LOG_EXP_W + LOG_FRAC;
   localparam int LOG_NORM_STAGES = 6;
   localparam int LOG_LATENCY     = LOG_NORM_STAGES + LOG_FRAC;

   // even-shift normalization of x^2+y^2+z^2 (shifts 32, 16, 8, 4, 2)
   localparam int TNORM_STAGES = 5;

   // timeline: register stage at which a value is available, accept edge loads stage 1
   localparam int T_SQ    = 2;
   localparam int T_S     = 3;
   localparam int T_T     = 4;
   localparam int T_RT    = T_S + SQRT_STAGES;
   localparam int T_R3    = T_T + SQRT_STAGES;
   localparam int T_TS    = T_T + TNORM_STAGES;
   localparam int T_ROOTN = T_TS + SQRT_STAGES;
   localparam int T_N     = T_ROOTN + 1;
   localparam int T_LN    = T_N + LOG_LATENCY;
   localparam int T_LS    = T_S + LOG_LATENCY;
   localparam int T_D     = T_LN + 1;
   localparam int T_P     = T_D + 1;
   localparam int PIPE_LATENCY = T_P + 1;

   localparam logic [29:0] LN2_Q30       = 30'd744261118;
   localparam logic [14:0] ETA_LIMIT     = 15'h2000;
   localparam logic [14:0] ETA_NEG_LIMIT = 15'h6000;
   localparam logic [19:0] RADIUS_MAX    = 20'hFFFFF;
   localparam logic [31:0] PHASE_HALF    = 32'h8000_0000;
   localparam logic [31:0] PHASE_ROUND   = 32'h0000_8000;

   // atan(2^-i) with a full turn of 2^32
   localparam logic [31:0] ATAN_TABLE [32] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
      32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
      32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
      32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
      32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
      32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
      32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
      32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
   };

   typedef struct packed {
      logic z_neg;
      logic z_nonzero;
      logic xy_nonzero;
   } hit_flags_type;

endpackage

>>> rtl/core/hcre_delay.sv
// fixed-depth delay line used to align side data with the long arithmetic units
// no dependencies
`timescale 1ns / 1ps

module hcre_delay #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 1
) (
   input  logic             clock,
   input  logic [WIDTH-1:0] din,
   output logic [WIDTH-1:0] dout
);

   logic [WIDTH-1:0] tap_ff [DEPTH];

   always_ff @(posedge clock) begin
      tap_ff[0] <= din;
      for (int i = 1; i < DEPTH; i++) begin
         tap_ff[i] <= tap_ff[i-1];
      end
   end

   assign dout = tap_ff[DEPTH-1];

endmodule

>>> rtl/core/hcre_isqrt.sv
// pipelined floor square root of a 64-bit value, one root bit per stage
// depends on hcre_pkg
`timescale 1ns / 1ps

module hcre_isqrt
   import hcre_pkg::*;
(
   input  logic        clock,
   input  logic [63:0] din,
   output logic [31:0] root
);

   logic [63:0] rem_q [SQRT_STAGES+1];
   logic [63:0] res_q [SQRT_STAGES+1];
   logic [63:0] rem_ff [SQRT_STAGES];
   logic [63:0] res_ff [SQRT_STAGES];

   assign rem_q[0] = din;
   assign res_q[0] = '0;

   for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_stage
      localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
      logic [63:0] trial;
      logic [63:0] rem_in;
      logic [63:0] res_in;

      always_comb begin
         trial = res_q[k] + BIT;
         if (rem_q[k] >= trial) begin
            rem_in = rem_q[k] - trial;
            res_in = (res_q[k] >> 1) + BIT;
         end else begin
            rem_in = rem_q[k];
            res_in = res_q[k] >> 1;
         end
      end

      always_ff @(posedge clock) begin
         rem_ff[k] <= rem_in;
         res_ff[k] <= res_in;
      end

      assign rem_q[k+1] = rem_ff[k];
      assign res_q[k+1] = res_ff[k];
   end

   assign root = res_q[SQRT_STAGES][31:0];

endmodule

>>> rtl/core/hcre_log2.sv
// pipelined log2 of a 64-bit value: leading-one search, then one squaring per fraction bit
// depends on hcre_pkg
`timescale 1ns / 1ps

module hcre_log2
   import hcre_pkg::*;
(
   input  logic             clock,
   input  logic [63:0]      din,
   output logic [LOG_W-1:0] dout
);

   logic [63:0]          nv_q  [LOG_NORM_STAGES+1];
   logic [LOG_EXP_W-1:0] cnt_q [LOG_NORM_STAGES+1];
   logic [63:0]          nv_ff  [LOG_NORM_STAGES];
   logic [LOG_EXP_W-1:0] cnt_ff [LOG_NORM_STAGES];

   assign nv_q[0]  = din;
   assign cnt_q[0] = '0;

   // shift by 32, 16, 8, 4, 2, 1 until the leading one sits at bit 63
   for (genvar k = 0; k < LOG_NORM_STAGES; k++) begin : g_norm
      localparam int AMT = 32 >> k;
      logic [63:0]          nv_in;
      logic [LOG_EXP_W-1:0] cnt_in;

      always_comb begin
         if (nv_q[k][63 -: AMT] == '0) begin
            nv_in  = nv_q[k] << AMT;
            cnt_in = cnt_q[k] + LOG_EXP_W'(AMT);
         end else begin
            nv_in  = nv_q[k];
            cnt_in = cnt_q[k];
         end
      end

      always_ff @(posedge clock) begin
         nv_ff[k]  <= nv_in;
         cnt_ff[k] <= cnt_in;
      end

      assign nv_q[k+1]  = nv_ff[k];
      assign cnt_q[k+1] = cnt_ff[k];
   end

   logic [31:0]          m_q    [LOG_FRAC+1];
   logic [LOG_FRAC-1:0]  frac_q [LOG_FRAC+1];
   logic [LOG_EXP_W-1:0] exp_q  [LOG_FRAC+1];
   logic [31:0]          m_ff    [LOG_FRAC];
   logic [LOG_FRAC-1:0]  frac_ff [LOG_FRAC];
   logic [LOG_EXP_W-1:0] exp_ff  [LOG_FRAC];

   assign m_q[0]    = nv_q[LOG_NORM_STAGES][63:32];
   assign frac_q[0] = '0;
   assign exp_q[0]  = LOG_EXP_W'(63) - cnt_q[LOG_NORM_STAGES];

   // mantissa in [1,2) with 31 fraction bits; squaring doubles the log
   for (genvar k = 0; k < LOG_FRAC; k++) begin : g_square
      logic [63:0]         prod;
      logic [32:0]         sq;
      logic [31:0]         m_in;
      logic [LOG_FRAC-1:0] frac_in;

      always_comb begin
         prod = m_q[k] * m_q[k];
         sq   = prod[63:31];
         if (sq[32]) begin
            m_in    = sq[32:1];
            frac_in = {frac_q[k][LOG_FRAC-2:0], 1'b1};
         end else begin
            m_in    = sq[31:0];
            frac_in = {frac_q[k][LOG_FRAC-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         m_ff[k]    <= m_in;
         frac_ff[k] <= frac_in;
         exp_ff[k]  <= exp_q[k];
      end

      assign m_q[k+1]    = m_ff[k];
      assign frac_q[k+1] = frac_ff[k];
      assign exp_q[k+1]  = exp_ff[k];
   end

   assign dout = {exp_q[LOG_FRAC], frac_q[LOG_FRAC]};

endmodule

>>> rtl/core/hcre_cordic.sv
// pipelined vectoring cordic giving the phase of (x, y) on a 32-bit full-turn scale
// depends on hcre_pkg
`timescale 1ns / 1ps

module hcre_cordic
   import hcre_pkg::*;
#(
   parameter int COORD_WIDTH  = 20,
   parameter int CORDIC_STEPS = 16
) (
   input  logic                          clock,
   input  logic signed [COORD_WIDTH-1:0] pos_x,
   input  logic signed [COORD_WIDTH-1:0] pos_y,
   output logic [31:0]                   phase
);

   localparam int GUARD = 60 - COORD_WIDTH;

   logic signed [63:0] xs_ff  [CORDIC_STEPS+1];
   logic signed [63:0] ys_ff  [CORDIC_STEPS+1];
   logic [31:0]        acc_ff [CORDIC_STEPS+1];

   logic signed [63:0] xw;
   logic signed [63:0] yw;
   logic signed [63:0] x0_in;
   logic signed [63:0] y0_in;
   logic [31:0]        acc0_in;

   // left half plane: turn by pi first
   always_comb begin
      xw = 64'(pos_x) <<< GUARD;
      yw = 64'(pos_y) <<< GUARD;
      if (pos_x[COORD_WIDTH-1]) begin
         x0_in   = -xw;
         y0_in   = -yw;
         acc0_in = PHASE_HALF;
      end else begin
         x0_in   = xw;
         y0_in   = yw;
         acc0_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      xs_ff[0]  <= x0_in;
      ys_ff[0]  <= y0_in;
      acc_ff[0] <= acc0_in;
   end

   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
      logic signed [63:0] x_in;
      logic signed [63:0] y_in;
      logic [31:0]        acc_in;

      always_comb begin
         if (!ys_ff[i][63]) begin
            x_in   = xs_ff[i] + (ys_ff[i] >>> i);
            y_in   = ys_ff[i] - (xs_ff[i] >>> i);
            acc_in = acc_ff[i] + ATAN_TABLE[i];
         end else begin
            x_in   = xs_ff[i] - (ys_ff[i] >>> i);
            y_in   = ys_ff[i] + (xs_ff[i] >>> i);
            acc_in = acc_ff[i] - ATAN_TABLE[i];
         end
      end

      always_ff @(posedge clock) begin
         xs_ff[i+1]  <= x_in;
         ys_ff[i+1]  <= y_in;
         acc_ff[i+1] <= acc_in;
      end
   end

   assign phase = acc_ff[CORDIC_STEPS];

endmodule

>>> rtl/core/hit_cartesian_to_rt_phi_eta_top.sv
// each accepted hit strobes its result on rsp_valid as it leaves the output register
// throughput: one hit per cycle, busy stays low; the receiver cannot stall
// path: input, squares and sums (4), even shift (5), root unit (32), numerator (1),
// log2 unit (26), log difference and ln 2 scale (2), output register (1)
// reset clears the valid pipeline only; payload stages are not reset
// depends on hcre_pkg, hcre_delay, hcre_isqrt, hcre_log2, hcre_cordic
`timescale 1ns / 1ps

module hit_cartesian_to_rt_phi_eta_top
   import hcre_pkg::*;
#(
   parameter int COORD_WIDTH  = 20,
   parameter int CORDIC_STEPS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic signed [COORD_WIDTH-1:0] req_pos_x,
   input  logic signed [COORD_WIDTH-1:0] req_pos_y,
   input  logic signed [COORD_WIDTH-1:0] req_pos_z,
   output logic                          rsp_valid,
   output logic [19:0]                   rsp_radius_transverse,
   output logic [19:0]                   rsp_radius_full,
   output logic signed [15:0]            rsp_azimuth,
   output logic signed [14:0]            rsp_pseudorapidity,
   output logic                          rsp_eta_clipped
);

   localparam int T_CORDIC = T_SQ + CORDIC_STEPS;

   // valid pipeline
   logic [PIPE_LATENCY-1:0] valid_ff;
   logic [PIPE_LATENCY-1:0] valid_in;

   assign busy     = 1'b0;
   assign valid_in = {valid_ff[PIPE_LATENCY-2:0], start & ~busy};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // stage 1: input registers
   logic signed [COORD_WIDTH-1:0] x1_ff, y1_ff, z1_ff;

   always_ff @(posedge clock) begin
      x1_ff <= req_pos_x;
      y1_ff <= req_pos_y;
      z1_ff <= req_pos_z;
   end

   // stage 2: magnitudes squared and flags
   logic [COORD_WIDTH-1:0]   ax, ay, az;
   logic [2*COORD_WIDTH-1:0] axsq, aysq, azsq;
   logic [63:0]              axsq_ff, aysq_ff, azsq_ff;
   logic [COORD_WIDTH-1:0]   az2_ff;
   hit_flags_type            flags_in, flags2_ff;

   always_comb begin
      ax   = x1_ff[COORD_WIDTH-1] ? (~x1_ff + 1'b1) : x1_ff;
      ay   = y1_ff[COORD_WIDTH-1] ? (~y1_ff + 1'b1) : y1_ff;
      az   = z1_ff[COORD_WIDTH-1] ? (~z1_ff + 1'b1) : z1_ff;
      axsq = ax * ax;
      aysq = ay * ay;
      azsq = az * az;
      flags_in.z_neg      = z1_ff[COORD_WIDTH-1];
      flags_in.z_nonzero  = |z1_ff;
      flags_in.xy_nonzero = (|x1_ff) | (|y1_ff);
   end

   always_ff @(posedge clock) begin
      axsq_ff   <= 64'(axsq);
      aysq_ff   <= 64'(aysq);
      azsq_ff   <= 64'(azsq);
      az2_ff    <= az;
      flags2_ff <= flags_in;
   end

   // stages 3 and 4: x^2+y^2, then x^2+y^2+z^2
   logic [63:0] s3_ff, azsq3_ff, t4_ff;

   always_ff @(posedge clock) begin
      s3_ff    <= axsq_ff + aysq_ff;
      azsq3_ff <= azsq_ff;
      t4_ff    <= s3_ff + azsq3_ff;
   end

   // radii
   logic [31:0] rt_root, r3_root, rt_al, r3_al;

   hcre_isqrt u_sqrt_rt (.clock(clock), .din(s3_ff), .root(rt_root));
   hcre_isqrt u_sqrt_r3 (.clock(clock), .din(t4_ff), .root(r3_root));

   hcre_delay #(.WIDTH(32), .DEPTH(T_P - T_RT)) u_dly_rt (
      .clock(clock), .din(rt_root), .dout(rt_al));
   hcre_delay #(.WIDTH(32), .DEPTH(T_P - T_R3)) u_dly_r3 (
      .clock(clock), .din(r3_root), .dout(r3_al));

   // azimuth
   logic [31:0] phase, phase_al;

   hcre_cordic #(.COORD_WIDTH(COORD_WIDTH), .CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
      .clock(clock), .pos_x(x1_ff), .pos_y(y1_ff), .phase(phase));

   hcre_delay #(.WIDTH(32), .DEPTH(T_P - T_CORDIC)) u_dly_phase (
      .clock(clock), .din(phase), .dout(phase_al));

   // even normalization of the full square sum
   logic [63:0] ts_q  [TNORM_STAGES+1];
   logic [5:0]  sh_q  [TNORM_STAGES+1];
   logic [63:0] ts_ff [TNORM_STAGES];
   logic [5:0]  sh_ff [TNORM_STAGES];

   assign ts_q[0] = t4_ff;
   assign sh_q[0] = '0;

   for (genvar k = 0; k < TNORM_STAGES; k++) begin : g_tnorm
      localparam int AMT = 32 >> k;
      logic [63:0] ts_in;
      logic [5:0]  sh_in;

      // shift only while the result stays below 2^62
      always_comb begin
         if (ts_q[k][63 -: (AMT + 2)] == '0) begin
            ts_in = ts_q[k] << AMT;
            sh_in = sh_q[k] + 6'(AMT);
         end else begin
            ts_in = ts_q[k];
            sh_in = sh_q[k];
         end
      end

      always_ff @(posedge clock) begin
         ts_ff[k] <= ts_in;
         sh_ff[k] <= sh_in;
      end

      assign ts_q[k+1] = ts_ff[k];
      assign sh_q[k+1] = sh_ff[k];
   end

   // numerator |z| + r3, scaled
   logic [31:0]            rootn;
   logic [5:0]             sh41, sh68;
   logic [COORD_WIDTH-1:0] az41;
   logic [63:0]            n_ff;

   hcre_isqrt u_sqrt_n (.clock(clock), .din(ts_q[TNORM_STAGES]), .root(rootn));

   hcre_delay #(.WIDTH(6), .DEPTH(T_ROOTN - T_TS)) u_dly_sh_a (
      .clock(clock), .din(sh_q[TNORM_STAGES]), .dout(sh41));
   hcre_delay #(.WIDTH(6), .DEPTH(T_LN - T_ROOTN)) u_dly_sh_b (
      .clock(clock), .din(sh41), .dout(sh68));
   hcre_delay #(.WIDTH(COORD_WIDTH), .DEPTH(T_ROOTN - T_SQ)) u_dly_az (
      .clock(clock), .din(az2_ff), .dout(az41));

   always_ff @(posedge clock) begin
      n_ff <= 64'(rootn) + (64'(az41) << sh41[5:1]);
   end

   // logarithms
   logic [LOG_W-1:0] log_n, log_s, log_s_al;

   hcre_log2 u_log_n (.clock(clock), .din(n_ff), .dout(log_n));
   hcre_log2 u_log_s (.clock(clock), .din(s3_ff), .dout(log_s));

   hcre_delay #(.WIDTH(LOG_W), .DEPTH(T_LN - T_LS)) u_dly_logs (
      .clock(clock), .din(log_s), .dout(log_s_al));

   // log2 difference, clamped at zero, then scaled by ln 2
   logic signed [28:0] d_wide;
   logic [27:0]        d_ff;
   logic [57:0]        prod_ff;

   always_comb begin
      d_wide = $signed({2'b00, log_n, 1'b0}) - $signed({3'b000, sh68, 20'd0})
             - $signed({3'b000, log_s_al});
   end

   always_ff @(posedge clock) begin
      d_ff    <= d_wide[28] ? 28'd0 : d_wide[27:0];
      prod_ff <= d_ff * LN2_Q30;
   end

   hit_flags_type flags_al;

   hcre_delay #(.WIDTH($bits(hit_flags_type)), .DEPTH(T_P - T_SQ)) u_dly_flags (
      .clock(clock), .din(flags2_ff), .dout(flags_al));

   // final stage
   logic [58:0] mag_rnd;
   logic [17:0] mag_wide;
   logic [14:0] mag;
   logic        clip;
   logic [31:0] phase_rnd;

   logic [19:0]        rt_in, r3_in;
   logic signed [15:0] az_in;
   logic signed [14:0] eta_in;

   always_comb begin
      mag_rnd  = 59'(prod_ff) + (59'd1 << 40);
      mag_wide = mag_rnd[58:41];
      if (!flags_al.z_nonzero) begin
         mag  = '0;
         clip = 1'b0;
      end else if (!flags_al.xy_nonzero || (mag_wide > 18'(ETA_LIMIT))) begin
         mag  = ETA_LIMIT;
         clip = 1'b1;
      end else begin
         mag  = mag_wide[14:0];
         clip = 1'b0;
      end
      eta_in    = flags_al.z_neg ? (~mag + 1'b1) : mag;
      phase_rnd = phase_al + PHASE_ROUND;
      az_in     = flags_al.xy_nonzero ? phase_rnd[31:16] : '0;
      rt_in     = (rt_al > 32'(RADIUS_MAX)) ? RADIUS_MAX : rt_al[19:0];
      r3_in     = (r3_al > 32'(RADIUS_MAX)) ? RADIUS_MAX : r3_al[19:0];
   end

   logic [19:0]        rt_ff, r3_ff;
   logic signed [15:0] az_ff;
   logic signed [14:0] eta_ff;
   logic               clip_ff;

   always_ff @(posedge clock) begin
      rt_ff   <= rt_in;
      r3_ff   <= r3_in;
      az_ff   <= az_in;
      eta_ff  <= eta_in;
      clip_ff <= clip;
   end

   assign rsp_valid             = valid_ff[PIPE_LATENCY-1];
   assign rsp_radius_transverse = rt_ff;
   assign rsp_radius_full       = r3_ff;
   assign rsp_azimuth           = az_ff;
   assign rsp_pseudorapidity    = eta_ff;
   assign rsp_eta_clipped       = clip_ff;

endmodule

>>> rtl/core/hcre_checker.sv
// port-level checks for the hit coordinate converter, bound to the top level
// depends on hcre_pkg and hit_cartesian_to_rt_phi_eta_top
`timescale 1ns / 1ps

module hcre_checker
   import hcre_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               start,
   input logic               busy,
   input logic               rsp_valid,
   input logic [19:0]        rsp_radius_transverse,
   input logic [19:0]        rsp_radius_full,
   input logic signed [15:0] rsp_azimuth,
   input logic signed [14:0] rsp_pseudorapidity,
   input logic               rsp_eta_clipped
);

   // every accepted transaction gives exactly one result at fixed latency
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##PIPE_LATENCY rsp_valid)
      else $error("accepted transaction produced no result");

   a_no_orphan: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, PIPE_LATENCY))
      else $error("result without an accepted transaction");

   a_clip_value: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_eta_clipped) |->
         (rsp_pseudorapidity == ETA_LIMIT || rsp_pseudorapidity == ETA_NEG_LIMIT))
      else $error("clipped pseudorapidity not at limit");

   a_origin_phi: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_radius_transverse == '0) |-> (rsp_azimuth == '0))
      else $error("nonzero azimuth at zero transverse radius");

   a_radius_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_radius_full >= rsp_radius_transverse))
      else $error("full radius below transverse radius");

endmodule

bind hit_cartesian_to_rt_phi_eta_top hcre_checker u_hcre_checker (.*);

>>> tb/tb.sv
// testbench for hit_cartesian_to_rt_phi_eta_top: directed and random hits against a predictor
// depends on hcre_pkg and the rtl of the block; the scoreboard class checks each result in order
`timescale 1ns / 1ps

module tb;
   import hcre_pkg::*;

   localparam int CW        = 20;
   localparam int STEPS     = 16;
   localparam int N_RANDOM  = 750;
   localparam int WD_LIMIT  = 5000;

   typedef struct {
      logic [19:0]        rt;
      logic [19:0]        r3;
      logic signed [15:0] phi;
      logic signed [14:0] eta;
      logic               clip;
   } hit_result_type;

   class hit_scoreboard;
      hit_result_type pending_q[$];
      int             errors = 0;

      task report(string msg);
         $display("tb: mismatch: %s", msg);
         errors++;
      endtask

      function automatic longint unsigned root64(longint unsigned v);
         longint unsigned res, bit_v;
         res = 0;
         bit_v = 64'd1 << 62;
         while (bit_v > v) bit_v >>= 2;
         while (bit_v != 0) begin
            if (v >= res + bit_v) begin
               v -= res + bit_v;
               res = (res >> 1) + bit_v;
            end else begin
               res >>= 1;
            end
            bit_v >>= 2;
         end
         return res;
      endfunction

      // log2 in q.20, leading one then repeated squaring
      function automatic longint unsigned log2_q20(longint unsigned v);
         int e;
         longint unsigned m, frac;
         e = 63;
         frac = 0;
         while (((v >> e) & 64'd1) == 0 && e > 0) e--;
         if (e >= 31) m = v >> (e - 31);
         else m = v << (31 - e);
         for (int i = 0; i < 20; i++) begin
            m = (m * m) >> 31;
            frac <<= 1;
            if (m >= (64'd2 << 31)) begin
               m >>= 1;
               frac |= 64'd1;
            end
         end
         return (longint'(e) << 20) | frac;
      endfunction

      function automatic logic [15:0] cordic_phase(longint x, longint y);
         logic [31:0] acc, rounded;
         longint cx, cy, dx, dy;
         acc = 0;
         cx = x <<< (60 - CW);
         cy = y <<< (60 - CW);
         if (cx < 0) begin
            cx = -cx;
            cy = -cy;
            acc = PHASE_HALF;
         end
         for (int i = 0; i < STEPS && i < 32; i++) begin
            dx = cy >>> i;
            dy = cx >>> i;
            if (cy >= 0) begin
               cx += dx; cy -= dy; acc += ATAN_TABLE[i];
            end else begin
               cx -= dx; cy += dy; acc -= ATAN_TABLE[i];
            end
         end
         rounded = acc + 32'h8000;
         return rounded[31:16];
      endfunction

      function automatic hit_result_type convert_hit(logic signed [CW-1:0] px,
                                                    logic signed [CW-1:0] py,
                                                    logic signed [CW-1:0] pz);
         hit_result_type r;
         longint x, y, z, d;
         longint unsigned ax, ay, az, s, t, rt, r3, mag, ts, n;
         logic [14:0] eta_bits;
         int sh;
         x = px; y = py; z = pz;
         ax = (x < 0) ? -x : x;
         ay = (y < 0) ? -y : y;
         az = (z < 0) ? -z : z;
         s = ax * ax + ay * ay;
         t = s + az * az;
         rt = root64(s);
         r3 = root64(t);
         mag = 0;
         r.clip = 0;
         r.phi = (x != 0 || y != 0) ? cordic_phase(x, y) : 16'sd0;
         if (z != 0) begin
            if (s == 0) begin
               mag = 8192;
               r.clip = 1;
            end else begin
               ts = t;
               sh = 0;
               while (ts < (64'd1 << 60)) begin
                  ts <<= 2;
                  sh += 2;
               end
               n = root64(ts) + (az << (sh / 2));
               d = 2 * longint'(log2_q20(n)) - (longint'(sh) << 20) - longint'(log2_q20(s));
               if (d < 0) d = 0;
               mag = (longint'(d) * 64'd744261118 + (64'd1 << 40)) >> 41;
               if (mag > 8192) begin
                  mag = 8192;
                  r.clip = 1;
               end
            end
         end
         r.rt = (rt > 64'hFFFFF) ? 20'hFFFFF : rt[19:0];
         r.r3 = (r3 > 64'hFFFFF) ? 20'hFFFFF : r3[19:0];
         eta_bits = (z < 0) ? (15'd0 - mag[14:0]) : mag[14:0];
         r.eta = eta_bits;
         return r;
      endfunction

      function void note_hit(logic signed [CW-1:0] px, logic signed [CW-1:0] py,
                             logic signed [CW-1:0] pz);
         pending_q.push_back(convert_hit(px, py, pz));
      endfunction

      task check_result(hit_result_type got);
         hit_result_type exp;
         if (pending_q.size() == 0) begin
            report("result with no transaction outstanding");
            return;
         end
         exp = pending_q.pop_front();
         if (got.rt !== exp.rt)
            report($sformatf("radius_transverse got %0d exp %0d", got.rt, exp.rt));
         if (got.r3 !== exp.r3)
            report($sformatf("radius_full got %0d exp %0d", got.r3, exp.r3));
         if (got.phi !== exp.phi)
            report($sformatf("azimuth got %0d exp %0d", got.phi, exp.phi));
         if (got.eta !== exp.eta)
            report($sformatf("pseudorapidity got %0d exp %0d", got.eta, exp.eta));
         if (got.clip !== exp.clip)
            report($sformatf("eta_clipped got %0b exp %0b", got.clip, exp.clip));
      endtask
   endclass

   logic                 clock = 0;
   logic                 reset = 1;
   logic                 start = 0;
   logic                 busy;
   logic signed [CW-1:0] req_pos_x = '0;
   logic signed [CW-1:0] req_pos_y = '0;
   logic signed [CW-1:0] req_pos_z = '0;
   logic                 rsp_valid;
   logic [19:0]          rsp_radius_transverse;
   logic [19:0]          rsp_radius_full;
   logic signed [15:0]   rsp_azimuth;
   logic signed [14:0]   rsp_pseudorapidity;
   logic                 rsp_eta_clipped;

   hit_scoreboard sb = new();
   bit            no_idle = 0;
   int            quiet_cycles = 0;

   hit_cartesian_to_rt_phi_eta_top #(.COORD_WIDTH(CW), .CORDIC_STEPS(STEPS)) DUT (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_pos_x(req_pos_x), .req_pos_y(req_pos_y), .req_pos_z(req_pos_z),
      .rsp_valid(rsp_valid), .rsp_radius_transverse(rsp_radius_transverse),
      .rsp_radius_full(rsp_radius_full), .rsp_azimuth(rsp_azimuth),
      .rsp_pseudorapidity(rsp_pseudorapidity), .rsp_eta_clipped(rsp_eta_clipped)
   );

   always begin
      #4 clock = 1;
      #4 clock = 0;
   end

   always @(posedge clock) begin
      hit_result_type got;
      if (!reset && start && !busy)
         sb.note_hit(req_pos_x, req_pos_y, req_pos_z);
      if (!reset && rsp_valid) begin
         got.rt   = rsp_radius_transverse;
         got.r3   = rsp_radius_full;
         got.phi  = rsp_azimuth;
         got.eta  = rsp_pseudorapidity;
         got.clip = rsp_eta_clipped;
         sb.check_result(got);
      end
   end

   // watchdog on cycles where no transaction moves on either side
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WD_LIMIT) begin
            $display("tb: errors");
            $finish;
         end
      end
   end

   task send_hit(logic signed [CW-1:0] px, logic signed [CW-1:0] py,
                 logic signed [CW-1:0] pz);
      if (!no_idle && $urandom_range(99) < 24) begin
         start <= 0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      start     <= 1;
      req_pos_x <= px;
      req_pos_y <= py;
      req_pos_z <= pz;
      do @(posedge clock); while (busy);
   endtask

   function automatic logic signed [CW-1:0] rand_coord(int kind);
      case (kind)
         0:       return CW'($urandom);
         1:       return CW'($signed($urandom_range(0, 512)) - 256);
         2:       return CW'($signed($urandom_range(0, 65536)) - 32768);
         default: return ($urandom_range(1) != 0) ? CW'(20'sh7FFFF - $urandom_range(15))
                                                  : CW'(20'sh80000 + $urandom_range(15));
      endcase
   endfunction

   localparam logic signed [CW-1:0] PMAX = 20'sh7FFFF;
   localparam logic signed [CW-1:0] PMIN = 20'sh80000;

   initial begin
      int kind;
      repeat (6) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // origin, z zero cases, rt zero, axes, extremes, large eta
      send_hit(0, 0, 0);
      send_hit(0, 0, 100);
      send_hit(0, 0, -100);
      send_hit(0, 0, PMAX);
      send_hit(0, 0, PMIN);
      send_hit(300, -400, 0);
      send_hit(PMAX, PMAX, PMAX);
      send_hit(PMIN, PMIN, PMIN);
      send_hit(PMIN, 0, 5);
      send_hit(-1, 0, 1);
      send_hit(0, PMAX, -7);
      send_hit(0, PMIN, 7);
      send_hit(1, 0, PMAX);
      send_hit(1, 1, PMIN);
      send_hit(-1, -1, 0);
      send_hit(PMAX, PMIN, 1);
      send_hit(PMIN, PMAX, -1);
      send_hit(1000, 1000, 1000);
      send_hit(-256, 256, -512);
      send_hit(PMAX, 0, 0);

      for (int i = 0; i < N_RANDOM; i++) begin
         no_idle = (i >= 300 && i < 450);
         if (i == 500) begin
            // hold off until the pipeline has drained
            start <= 0;
            while (sb.pending_q.size() != 0) @(posedge clock);
         end
         kind = $urandom_range(9);
         if (kind < 4)
            send_hit(rand_coord(0), rand_coord(0), rand_coord(0));
         else if (kind < 6)
            send_hit(rand_coord(1), rand_coord(1), rand_coord(2));
         else if (kind < 8)
            send_hit(rand_coord($urandom_range(3)), rand_coord($urandom_range(3)),
                     rand_coord($urandom_range(3)));
         else
            // tiny transverse radius, long z: drives eta toward the clip
            send_hit(CW'($signed($urandom_range(0, 4)) - 2),
                     CW'($signed($urandom_range(0, 4)) - 2), rand_coord(0));
      end
      start <= 0;

      while (sb.pending_q.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (sb.errors == 0 && sb.pending_q.size() == 0) begin
         $display("tb: clean");
      end else begin
         $display("tb: errors");
      end
      $finish;
   end

endmodule

>>> filelist.f
rtl/core/hcre_pkg.sv
rtl/core/hcre_delay.sv
rtl/core/hcre_isqrt.sv
rtl/core/hcre_log2.sv
rtl/core/hcre_cordic.sv
rtl/core/hit_cartesian_to_rt_phi_eta_top.sv
rtl/core/hcre_checker.sv
tb/tb.sv
